FILE: src/lsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsq_pkg: shared types and codes of the linear scan priority queue
// Command and response words, table entry layout and action/status codes.
// ----------------------------------------------------------------------------

package lsq_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int TAG_BITS  = 32;
	localparam int PRIO_BITS = 16;
	localparam int CNT_BITS  = 7;

	localparam logic [1:0] ACT_INSERT  = 2'd0;
	localparam logic [1:0] ACT_EXTRACT = 2'd1;
	localparam logic [1:0] ACT_PEEK    = 2'd2;
	localparam logic [1:0] ACT_MODIFY  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic [1:0]           action;
		logic [TAG_BITS-1:0]  key_tag;
		logic [PRIO_BITS-1:0] prio_in;
	} cmd_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [TAG_BITS-1:0]  out_tag;
		logic [PRIO_BITS-1:0] out_prio;
		logic [CNT_BITS-1:0]  entry_count;
	} rsp_t;

	typedef struct packed {
		logic [TAG_BITS-1:0]  tag;
		logic [PRIO_BITS-1:0] prio;
	} entry_t;

endpackage

FILE: src/linear_scan_priority_queue.sv
`timescale 1ns / 1ps
// Insert finishes in the dispatch state; peek and extract scan the whole table
// from the newest entry down, modify stops at the newest matching tag, and an
// extract that does not remove the newest entry shifts each newer one down.
// All of it is set by the single read port of the entry memory, walked one
// entry per cycle. Throughput: one word at a time; a new word is taken in the
// cycle done shows. Reset clears the count and control only, not the memory.
// ----------------------------------------------------------------------------
// linear_scan_priority_queue
// Bounded max-priority queue kept as an unsorted table in insertion order.
// ----------------------------------------------------------------------------

module linear_scan_priority_queue #(
	parameter int DEPTH = lsq_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lsq_pkg::cmd_t cmd,
	output logic          done,
	output lsq_pkg::rsp_t rsp
);

	// Index width of the table and width of the entry count (holds DEPTH).
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a command word
	localparam logic [2:0] S_DISP  = 3'd1;  // decode, insert is finished here
	localparam logic [2:0] S_SCAN  = 3'd2;  // search for the maximum
	localparam logic [2:0] S_FIND  = 3'd3;  // search for the newest matching tag
	localparam logic [2:0] S_SHIFT = 3'd4;  // close the gap after an extract

	// The entry table. Slot 0 holds the oldest entry. One write port and one
	// read port with registered read data.
	lsq_pkg::entry_t mem [DEPTH];

	logic [2:0]       state_q;
	lsq_pkg::cmd_t    cmd_q;
	logic [CW-1:0]    occ_q;

	// Read pipeline: idx_q is the address issued this cycle, the _s1 registers
	// carry the returning word and the address it came from.
	logic [AW-1:0]    idx_q;
	logic             issue_q;
	logic             rv_s1;
	logic [AW-1:0]    ridx_s1;
	lsq_pkg::entry_t  rdata_s1;

	// Best entry seen so far by the maximum search.
	lsq_pkg::entry_t  best_q;
	logic [AW-1:0]    bidx_q;
	logic             have_best_q;

	logic             done_q;
	lsq_pkg::rsp_t    rsp_q;

	logic             mem_re;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	lsq_pkg::entry_t  mem_wdata;

	logic             full;
	logic             empty;
	logic [AW-1:0]    last_idx;
	logic             take;
	lsq_pkg::entry_t  nb_ent;
	logic [AW-1:0]    nb_idx;
	logic             hit;

	function automatic logic [lsq_pkg::CNT_BITS-1:0] cnt7(input logic [CW-1:0] c);
		logic [CW+lsq_pkg::CNT_BITS-1:0] e;
		e = {{lsq_pkg::CNT_BITS{1'b0}}, c};
		return e[lsq_pkg::CNT_BITS-1:0];
	endfunction

	// Packs a complete response word.
	function automatic lsq_pkg::rsp_t rsp_word(input logic [1:0] st,
			input lsq_pkg::entry_t ent, input logic [CW-1:0] c);
		lsq_pkg::rsp_t r;
		r.status      = st;
		r.out_tag     = ent.tag;
		r.out_prio    = ent.prio;
		r.entry_count = cnt7(c);
		return r;
	endfunction

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	assign full     = (occ_q == CW'(DEPTH));
	assign empty    = (occ_q == '0);
	assign last_idx = AW'(occ_q - CW'(1));
	assign mem_re   = issue_q;
	assign hit      = rv_s1 && (rdata_s1.tag == cmd_q.key_tag);

	// The scan runs from the newest slot down, so a strictly greater priority
	// is needed to replace the current best: ties stay with the newer entry.
	assign take   = rv_s1 && (!have_best_q || (rdata_s1.prio > best_q.prio));
	assign nb_ent = take ? rdata_s1 : best_q;
	assign nb_idx = take ? ridx_s1 : bidx_q;

	// Memory write decode. Reads and writes in the same cycle always touch
	// different slots (modify reads below its hit, the shift reads two slots
	// above the one it writes), so no forwarding is needed.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(occ_q);
		mem_wdata = '{tag: cmd_q.key_tag, prio: cmd_q.prio_in};
		unique case (state_q)
			S_DISP: begin
				if ((cmd_q.action == lsq_pkg::ACT_INSERT) && !full) begin
					mem_we = 1'b1;
				end
			end
			S_FIND: begin
				if (hit) begin
					mem_we    = 1'b1;
					mem_waddr = ridx_s1;
					mem_wdata = '{tag: rdata_s1.tag, prio: cmd_q.prio_in};
				end
			end
			S_SHIFT: begin
				if (rv_s1) begin
					mem_we    = 1'b1;
					mem_waddr = ridx_s1 - AW'(1);
					mem_wdata = rdata_s1;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_s1 <= mem[idx_q];
		end
		ridx_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			occ_q       <= '0;
			idx_q       <= '0;
			issue_q     <= 1'b0;
			rv_s1       <= 1'b0;
			best_q      <= '0;
			bidx_q      <= '0;
			have_best_q <= 1'b0;
			done_q      <= 1'b0;
			rsp_q       <= '0;
		end else begin
			done_q <= 1'b0;
			rv_s1  <= mem_re;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					have_best_q <= 1'b0;
					idx_q       <= last_idx;
					unique case (cmd_q.action)
						lsq_pkg::ACT_INSERT: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
							if (full) begin
								rsp_q <= rsp_word(lsq_pkg::ST_FULL, '0, occ_q);
							end else begin
								occ_q <= occ_q + CW'(1);
								rsp_q <= rsp_word(lsq_pkg::ST_OK, '0, occ_q + CW'(1));
							end
						end
						lsq_pkg::ACT_EXTRACT, lsq_pkg::ACT_PEEK: begin
							if (empty) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
								rsp_q   <= rsp_word(lsq_pkg::ST_EMPTY, '0, occ_q);
							end else begin
								issue_q <= 1'b1;
								state_q <= S_SCAN;
							end
						end
						default: begin
							if (empty) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
								rsp_q   <= rsp_word(lsq_pkg::ST_NOTFOUND, '0, occ_q);
							end else begin
								issue_q <= 1'b1;
								state_q <= S_FIND;
							end
						end
					endcase
				end
				S_SCAN: begin
					if (issue_q) begin
						if (idx_q == '0) begin
							issue_q <= 1'b0;
						end else begin
							idx_q <= idx_q - AW'(1);
						end
					end
					if (rv_s1) begin
						best_q      <= nb_ent;
						bidx_q      <= nb_idx;
						have_best_q <= 1'b1;
					end
					if (rv_s1 && (ridx_s1 == '0)) begin
						if (cmd_q.action == lsq_pkg::ACT_PEEK) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
							rsp_q   <= rsp_word(lsq_pkg::ST_OK, nb_ent, occ_q);
						end else if (nb_idx == last_idx) begin
							// The newest entry was removed: nothing to shift.
							done_q  <= 1'b1;
							state_q <= S_IDLE;
							occ_q   <= occ_q - CW'(1);
							rsp_q   <= rsp_word(lsq_pkg::ST_OK, nb_ent, occ_q - CW'(1));
						end else begin
							// The maximum stays in best_q for the response.
							idx_q   <= nb_idx + AW'(1);
							issue_q <= 1'b1;
							state_q <= S_SHIFT;
						end
					end
				end
				S_FIND: begin
					if (hit) begin
						// The read issued in this cycle is dropped on the way out.
						issue_q <= 1'b0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						rsp_q   <= rsp_word(lsq_pkg::ST_OK, '0, occ_q);
					end else begin
						if (issue_q) begin
							if (idx_q == '0) begin
								issue_q <= 1'b0;
							end else begin
								idx_q <= idx_q - AW'(1);
							end
						end
						if (rv_s1 && (ridx_s1 == '0)) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
							rsp_q   <= rsp_word(lsq_pkg::ST_NOTFOUND, '0, occ_q);
						end
					end
				end
				S_SHIFT: begin
					if (issue_q) begin
						if (idx_q == last_idx) begin
							issue_q <= 1'b0;
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
					if (rv_s1 && (ridx_s1 == last_idx)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						occ_q   <= occ_q - CW'(1);
						rsp_q   <= rsp_word(lsq_pkg::ST_OK, best_q, occ_q - CW'(1));
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// The count can never pass the table depth.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("entry count above depth");

	// An accepted command word always occupies the sequencer next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not start work");

	// A response only closes a command that was being worked on.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("response without a command in progress");

	// No memory read may be left outstanding once the sequencer is idle.
	a_idle_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !done) |-> !issue_q)
		else $error("read issued while idle");
`endif

endmodule
